[design/menu_script_tokenizer_top_defines.svh]
// Assertion macros shared by the tokenizer RTL
`ifndef MENU_SCRIPT_TOKENIZER_TOP_DEFINES_SVH
`define MENU_SCRIPT_TOKENIZER_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define MTS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is high
`define MTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/mts_pkg.sv]
// Shared types, constants and helper functions of the menu script tokenizer
package mts_pkg;

   localparam int MAX_RES     = 4;
   localparam int QUEUE_DEPTH = 4;
   localparam int KW_COUNT    = 13;

   localparam logic RK_TEXT = 1'b0;
   localparam logic RK_CODE = 1'b1;

   localparam logic [4:0] TK_EOF         = 5'd0;
   localparam logic [4:0] TK_IDENT       = 5'd1;
   localparam logic [4:0] TK_STRING      = 5'd2;
   localparam logic [4:0] TK_CONST       = 5'd3;
   localparam logic [4:0] TK_KEY0        = 5'd4;
   localparam logic [4:0] TK_INVALID     = 5'd17;
   localparam logic [4:0] TK_EOF_COMMENT = 5'd18;
   localparam logic [4:0] TK_NESTED      = 5'd19;

   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_QUOTE = 8'd34;
   localparam logic [7:0] CH_STAR  = 8'd42;
   localparam logic [7:0] CH_SLASH = 8'd47;
   localparam logic [7:0] CH_BSL   = 8'd92;

   localparam logic [47:0] KW_TEXT [KW_COUNT] = '{
      "menu  ", "prompt", "line  ", "color ", "hilite", "key   ", "type  ",
      "auto  ", "expert", "data  ", "priv  ", "flags ", "define"
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd4, 3'd6, 3'd4, 3'd5, 3'd6, 3'd3, 3'd4, 3'd4, 3'd6, 3'd4, 3'd4, 3'd5, 3'd6
   };

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  text_char;
      logic [4:0]  token_code;
      logic [15:0] const_value;
      logic        const_overflow;
   } entry_type;

   typedef struct packed {
      logic [2:0]                count;
      entry_type [MAX_RES-1:0]   res;
   } record_type;

   function automatic logic is_space(input logic [7:0] c);
      return c inside {8'd32, [8'd9:8'd13]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return c inside {[8'd65:8'd90], [8'd97:8'd122]};
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'd48:8'd57]};
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c inside {[8'd65:8'd90]}) ? (c + 8'd32) : c;
   endfunction

   function automatic entry_type make_text(input logic [7:0] c);
      entry_type e;
      e = '0;
      e.result_kind = RK_TEXT;
      e.text_char   = c;
      return e;
   endfunction

   function automatic entry_type make_code(input logic [4:0] code);
      entry_type e;
      e = '0;
      e.result_kind = RK_CODE;
      e.token_code  = code;
      return e;
   endfunction

   function automatic entry_type make_const(input logic [15:0] v, input logic ovf);
      entry_type e;
      e = '0;
      e.result_kind    = RK_CODE;
      e.token_code     = TK_CONST;
      e.const_value    = v;
      e.const_overflow = ovf;
      return e;
   endfunction

   // value*10 + digit, keeping the low 16 bits; returns {overflow, value}
   function automatic logic [16:0] num_step(input logic [15:0] v, input logic ovf,
                                            input logic [7:0] c);
      logic [19:0] sum;
      sum = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {16'd0, c[3:0]};
      return {ovf | (sum[19:16] != 4'd0), sum[15:0]};
   endfunction

   function automatic logic [4:0] kw_lookup(input logic [5:0][7:0] word,
                                            input logic [2:0] len);
      logic [4:0] code;
      logic       same;
      code = TK_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         same = (len == KW_LEN[k]);
         for (int i = 0; i < 6; i++) begin
            if (i < int'(KW_LEN[k]) && word[i] != KW_TEXT[k][47 - 8*i -: 8]) begin
               same = 1'b0;
            end
         end
         if (same) begin
            code = TK_KEY0 + 5'(k);
         end
      end
      return code;
   endfunction

endpackage

[design/mts_front.sv]
// Front end: accepts bytes, runs the scanner state and builds at most one result record per transfer
module mts_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_kind,
   input  logic [7:0]          req_source_char,
   input  logic                queue_full,
   output logic                push,
   output mts_pkg::record_type push_data
);

   localparam logic [2:0] MODE_START   = 3'd0;
   localparam logic [2:0] MODE_IDENT   = 3'd1;
   localparam logic [2:0] MODE_CONST   = 3'd2;
   localparam logic [2:0] MODE_STRING  = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;

   logic [2:0]       mode_ff, mode_in;
   logic [7:0]       held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic             skip_ff, skip_in;
   logic [5:0][7:0]  word_ff, word_in;
   logic [2:0]       len_ff, len_in;
   logic [15:0]      num_ff, num_in;
   logic             ovf_ff, ovf_in;

   mts_pkg::record_type rec_in;
   logic [2:0]          cnt_in;
   logic                consume;
   logic                restart;
   logic                has_nx;
   logic                accept;
   logic [16:0]         num_nx;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign has_nx    = !req_kind;

   always_comb begin
      mode_in       = mode_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      skip_in       = skip_ff;
      word_in       = word_ff;
      len_in        = len_ff;
      num_in        = num_ff;
      ovf_in        = ovf_ff;
      rec_in        = '0;
      cnt_in        = 3'd0;
      consume       = 1'b0;
      restart       = 1'b0;
      num_nx        = '0;
      if (accept) begin
         if (held_valid_ff && !skip_ff) begin
            case (mode_ff)
               MODE_IDENT: begin
                  if (mts_pkg::is_alpha(held_ff) || mts_pkg::is_digit(held_ff)) begin
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_text(held_ff);
                     cnt_in = cnt_in + 3'd1;
                     if (len_in < 3'd6) begin
                        word_in[len_in] = mts_pkg::to_lower(held_ff);
                        len_in = len_in + 3'd1;
                     end else begin
                        len_in = 3'd7;
                     end
                  end else begin
                     rec_in.res[cnt_in[1:0]] =
                        mts_pkg::make_code(mts_pkg::kw_lookup(word_in, len_in));
                     cnt_in = cnt_in + 3'd1;
                     restart = 1'b1;
                  end
               end
               MODE_CONST: begin
                  if (mts_pkg::is_digit(held_ff)) begin
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_text(held_ff);
                     cnt_in = cnt_in + 3'd1;
                     num_nx = mts_pkg::num_step(num_in, ovf_in, held_ff);
                     num_in = num_nx[15:0];
                     ovf_in = num_nx[16];
                  end else begin
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_const(num_in, ovf_in);
                     cnt_in = cnt_in + 3'd1;
                     restart = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (held_ff == mts_pkg::CH_QUOTE) begin
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_STRING);
                     cnt_in = cnt_in + 3'd1;
                     mode_in = MODE_START;
                  end else if (held_ff == mts_pkg::CH_BSL && has_nx &&
                               req_source_char == mts_pkg::CH_QUOTE) begin
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_text(mts_pkg::CH_QUOTE);
                     cnt_in = cnt_in + 3'd1;
                     consume = 1'b1;
                  end else if (held_ff == mts_pkg::CH_LF) begin
                     // the line break itself yields nothing more
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_INVALID);
                     cnt_in = cnt_in + 3'd1;
                     mode_in = MODE_START;
                  end else begin
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_text(held_ff);
                     cnt_in = cnt_in + 3'd1;
                  end
               end
               MODE_COMMENT: begin
                  if (held_ff == mts_pkg::CH_STAR && has_nx &&
                      req_source_char == mts_pkg::CH_SLASH) begin
                     mode_in = MODE_START;
                     consume = 1'b1;
                  end else if (held_ff == mts_pkg::CH_SLASH && has_nx &&
                               req_source_char == mts_pkg::CH_STAR) begin
                     rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_NESTED);
                     cnt_in = cnt_in + 3'd1;
                  end
               end
               default: begin
                  restart = 1'b1;
               end
            endcase

            if (restart) begin
               mode_in = MODE_START;
               if (mts_pkg::is_space(held_ff)) begin
                  mode_in = MODE_START;
               end else if (held_ff == mts_pkg::CH_QUOTE) begin
                  mode_in = MODE_STRING;
               end else if (mts_pkg::is_alpha(held_ff)) begin
                  mode_in = MODE_IDENT;
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_text(held_ff);
                  cnt_in = cnt_in + 3'd1;
                  word_in[0] = mts_pkg::to_lower(held_ff);
                  len_in = 3'd1;
               end else if (held_ff == mts_pkg::CH_SLASH && has_nx &&
                            req_source_char == mts_pkg::CH_STAR) begin
                  mode_in = MODE_COMMENT;
                  consume = 1'b1;
               end else if (mts_pkg::is_digit(held_ff)) begin
                  mode_in = MODE_CONST;
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_text(held_ff);
                  cnt_in = cnt_in + 3'd1;
                  num_in = {12'd0, held_ff[3:0]};
                  ovf_in = 1'b0;
               end else begin
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_text(held_ff);
                  cnt_in = cnt_in + 3'd1;
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_INVALID);
                  cnt_in = cnt_in + 3'd1;
               end
            end
         end

         if (has_nx) begin
            skip_in       = held_valid_ff && !skip_ff && consume;
            held_in       = req_source_char;
            held_valid_in = 1'b1;
         end else begin
            case (mode_in)
               MODE_IDENT: begin
                  rec_in.res[cnt_in[1:0]] =
                     mts_pkg::make_code(mts_pkg::kw_lookup(word_in, len_in));
                  cnt_in = cnt_in + 3'd1;
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_EOF);
                  cnt_in = cnt_in + 3'd1;
               end
               MODE_CONST: begin
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_const(num_in, ovf_in);
                  cnt_in = cnt_in + 3'd1;
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_EOF);
                  cnt_in = cnt_in + 3'd1;
               end
               MODE_STRING: begin
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_INVALID);
                  cnt_in = cnt_in + 3'd1;
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_EOF);
                  cnt_in = cnt_in + 3'd1;
               end
               MODE_COMMENT: begin
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_EOF_COMMENT);
                  cnt_in = cnt_in + 3'd1;
               end
               default: begin
                  rec_in.res[cnt_in[1:0]] = mts_pkg::make_code(mts_pkg::TK_EOF);
                  cnt_in = cnt_in + 3'd1;
               end
            endcase
            mode_in       = MODE_START;
            held_in       = 8'd0;
            held_valid_in = 1'b0;
            skip_in       = 1'b0;
         end
         rec_in.count = cnt_in;
      end
   end

   assign push      = accept && (cnt_in != 3'd0);
   assign push_data = rec_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_START;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         skip_ff       <= 1'b0;
         len_ff        <= 3'd0;
         num_ff        <= 16'd0;
         ovf_ff        <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         skip_ff       <= skip_in;
         len_ff        <= len_in;
         num_ff        <= num_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

endmodule

[design/mts_fifo.sv]
// Record queue between the scanner front end and the result back end
module mts_fifo #(
   parameter int DEPTH = mts_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mts_pkg::record_type push_data,
   output logic                full,
   input  logic                pop,
   output mts_pkg::record_type head,
   output logic                empty
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   mts_pkg::record_type mem_ff [DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/mts_back.sv]
// Back end: walks the head record one result per transfer into the output register
module mts_back (
   input  logic                clock,
   input  logic                reset,
   input  mts_pkg::record_type head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_result_kind,
   output logic [7:0]          rsp_text_char,
   output logic [4:0]          rsp_token_code,
   output logic [15:0]         rsp_const_value,
   output logic                rsp_const_overflow,
   output logic                rsp_last
);

   localparam int IW = $clog2(mts_pkg::MAX_RES);

   logic [IW-1:0]      idx_ff, idx_in;
   logic               valid_ff, valid_in;
   mts_pkg::entry_type out_ff;
   logic               last_ff;
   logic               load;
   logic               is_last;

   assign load    = !empty && (!valid_ff || rsp_ready);
   assign is_last = ({1'b0, idx_ff} + 1'b1) == head.count;
   assign pop     = load && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = is_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff  <= head.res[idx_ff];
         last_ff <= is_last;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_result_kind    = out_ff.result_kind;
   assign rsp_text_char      = out_ff.text_char;
   assign rsp_token_code     = out_ff.token_code;
   assign rsp_const_value    = out_ff.const_value;
   assign rsp_const_overflow = out_ff.const_overflow;
   assign rsp_last           = last_ff;

endmodule

[design/menu_script_tokenizer_top.sv]
// The first result caused by a transfer passes the queue write, then the output register; a byte
// is scanned when the next transfer arrives, as it waits as lookahead.
// Throughput: one byte per cycle while the record queue has room; one result leaves per cycle
// while rsp_ready is high, and a byte can cause up to 4 results.
// Bytes that cause no result push no record into the queue.
// Reset (synchronous, active high): start mode, no held byte, queue and output register empty;
// bytes are taken from the first cycle after reset falls.
`include "menu_script_tokenizer_top_defines.svh"

module menu_script_tokenizer_top #(
   parameter int QUEUE_DEPTH = mts_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [7:0]  req_source_char,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_result_kind,
   output logic [7:0]  rsp_text_char,
   output logic [4:0]  rsp_token_code,
   output logic [15:0] rsp_const_value,
   output logic        rsp_const_overflow,
   output logic        rsp_last
);

   logic                push;
   mts_pkg::record_type push_data;
   logic                queue_full;
   logic                pop;
   mts_pkg::record_type head;
   logic                queue_empty;

   mts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_source_char (req_source_char),
      .queue_full      (queue_full),
      .push            (push),
      .push_data       (push_data)
   );

   mts_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   mts_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .empty              (queue_empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_text_char      (rsp_text_char),
      .rsp_token_code     (rsp_token_code),
      .rsp_const_value    (rsp_const_value),
      .rsp_const_overflow (rsp_const_overflow),
      .rsp_last           (rsp_last)
   );

   `MTS_ASSERT_NOW(a_push_not_full, clock, reset, push, !queue_full, "push into full queue")
   `MTS_ASSERT_NOW(a_pop_not_empty, clock, reset, pop, !queue_empty, "pop from empty queue")
   `MTS_ASSERT_NOW(a_push_count, clock, reset, push,
                   (push_data.count != 3'd0) && (push_data.count <= 3'd4), "bad record count")
   `MTS_ASSERT_NEXT(a_last_pops, clock, reset, pop, rsp_valid && rsp_last, "record end not shown as last")

endmodule
